// File: design/bwbs_pkg.sv
`default_nettype none

package bwbs_pkg;

   localparam int WINDOW_BYTES_DEFAULT = 65536;
   localparam int QUEUE_DEPTH_DEFAULT  = 4;

   localparam int PITCH_W   = 15;
   localparam int BPP_W     = 3;
   localparam int GRAN_W    = 7;
   localparam int ROW_Y_W   = 11;
   localparam int ROW_X_W   = 12;
   localparam int WIDTH_W   = 13;
   localparam int ADDR_SRC_W = 32;
   localparam int LEN_W     = 15;
   localparam int POS_W     = 16;
   localparam int OFFS_W    = 16;
   localparam int CACHE_W   = 10;
   // pitch * y + x * bpp fits in 27 bits for every register value
   localparam int ADDR_W    = 27;
   localparam int MAX_COPY  = 16384;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PITCH     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRANULES        = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_WINDOW_A    = 4'd3;

   localparam logic CMD_COPY   = 1'b0;
   localparam logic CMD_SELECT = 1'b1;

   typedef struct packed {
      logic [PITCH_W-1:0] frame_pitch;
      logic [BPP_W-1:0]   bytes_per_pixel;
      logic [GRAN_W-1:0]  granules_per_bank;
      logic               use_window_a;
   } cfg_type;

   // one classified row, as the back end needs it
   typedef struct packed {
      logic                  sel_first;
      logic                  split;
      logic                  final_row;
      logic                  window_sel;
      logic [POS_W-1:0]      bank_pos0;
      logic [POS_W-1:0]      bank_pos1;
      logic [OFFS_W-1:0]     offset;
      logic [ADDR_SRC_W-1:0] src0;
      logic [ADDR_SRC_W-1:0] src1;
      logic [LEN_W-1:0]      len0;
      logic [LEN_W-1:0]      len1;
   } row_cmd_type;

endpackage

`default_nettype wire

// File: design/bwbs_front.sv
`default_nettype none

module bwbs_front #(
   parameter int WINDOW_BYTES = bwbs_pkg::WINDOW_BYTES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bwbs_pkg::cfg_type               cfg,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [bwbs_pkg::ROW_Y_W-1:0]    req_row_y,
   input  wire logic [bwbs_pkg::ROW_X_W-1:0]    req_row_x,
   input  wire logic [bwbs_pkg::WIDTH_W-1:0]    req_width_pixels,
   input  wire logic [bwbs_pkg::ADDR_SRC_W-1:0] req_source_address,
   input  wire logic                            req_final_row,
   output logic                                 q_push,
   output bwbs_pkg::row_cmd_type                q_data,
   input  wire logic                            q_full
);
   import bwbs_pkg::*;

   localparam int WIN_BITS = $clog2(WINDOW_BYTES);
   localparam int BANK_W   = ADDR_W - WIN_BITS;
   localparam logic [16:0] WIN_END = 17'(WINDOW_BYTES);

   // stage a: products
   logic                     a_valid_ff, a_valid_in;
   logic [25:0]              a_py_ff;
   logic [14:0]              a_xb_ff;
   logic [15:0]              a_lb_ff;
   logic [ADDR_SRC_W-1:0]    a_src_ff;
   logic                     a_fin_ff;
   // stage b: address and clipped length
   logic                     b_valid_ff, b_valid_in;
   logic [ADDR_W-1:0]        b_addr_ff;
   logic [LEN_W-1:0]         b_len_ff;
   logic [ADDR_SRC_W-1:0]    b_src_ff;
   logic                     b_fin_ff;
   // bank cache, tracked in item order
   logic [CACHE_W-1:0]       cur_bank_ff, cur_bank_in;
   logic                     bank_known_ff, bank_known_in;

   logic                     a_take, a_move, b_take;
   logic [BANK_W-1:0]        bank;
   logic [15:0]              bank_ext, bank_inc;
   logic [16:0]              offset_ext, end_sum, first17;
   logic [LEN_W-1:0]         first, rest, rest_clip;
   logic [22:0]              prod0, prod1;
   logic                     len_zero, need_sel, split;

   assign b_take    = !b_valid_ff || q_push;
   assign a_move    = a_valid_ff && b_take;
   assign a_take    = !a_valid_ff || a_move;
   assign req_ready = a_take;
   assign q_push    = b_valid_ff && !q_full;

   assign a_valid_in = a_take ? req_valid : a_valid_ff;
   assign b_valid_in = b_take ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         cur_bank_ff   <= '0;
         bank_known_ff <= 1'b0;
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         cur_bank_ff   <= cur_bank_in;
         bank_known_ff <= bank_known_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         a_py_ff  <= 26'(cfg.frame_pitch) * 26'(req_row_y);
         a_xb_ff  <= 15'(req_row_x) * 15'(cfg.bytes_per_pixel);
         a_lb_ff  <= 16'(req_width_pixels) * 16'(cfg.bytes_per_pixel);
         a_src_ff <= req_source_address;
         a_fin_ff <= req_final_row;
      end
      if (b_take) begin
         b_addr_ff <= {1'b0, a_py_ff} + ADDR_W'(a_xb_ff);
         b_len_ff  <= (a_lb_ff > 16'(MAX_COPY)) ? LEN_W'(MAX_COPY) : a_lb_ff[LEN_W-1:0];
         b_src_ff  <= a_src_ff;
         b_fin_ff  <= a_fin_ff;
      end
   end

   // classify against the cached bank
   always_comb begin
      bank       = b_addr_ff[ADDR_W-1:WIN_BITS];
      bank_ext   = 16'(bank);
      bank_inc   = bank_ext + 16'd1;
      offset_ext = 17'(b_addr_ff[WIN_BITS-1:0]);
      len_zero   = (b_len_ff == '0);
      need_sel   = !len_zero && (!bank_known_ff || bank_ext[CACHE_W-1:0] != cur_bank_ff);
      end_sum    = offset_ext + 17'(b_len_ff);
      split      = end_sum > WIN_END;
      // first < len when split, so it fits the length width
      first17    = WIN_END - offset_ext;
      first      = first17[LEN_W-1:0];
      rest       = b_len_ff - first;
      rest_clip  = (17'(rest) > WIN_END) ? LEN_W'(WINDOW_BYTES) : rest;
      prod0      = 23'(bank_ext) * 23'(cfg.granules_per_bank);
      prod1      = 23'(bank_inc) * 23'(cfg.granules_per_bank);

      q_data.sel_first  = need_sel;
      q_data.split      = split;
      q_data.final_row  = b_fin_ff;
      q_data.window_sel = ~cfg.use_window_a;
      q_data.bank_pos0  = prod0[POS_W-1:0];
      q_data.bank_pos1  = prod1[POS_W-1:0];
      q_data.offset     = OFFS_W'(b_addr_ff[WIN_BITS-1:0]);
      q_data.src0       = b_src_ff;
      q_data.src1       = b_src_ff + ADDR_SRC_W'(first);
      q_data.len0       = split ? first : b_len_ff;
      q_data.len1       = rest_clip;

      cur_bank_in   = cur_bank_ff;
      bank_known_in = bank_known_ff;
      if (q_push && !len_zero) begin
         bank_known_in = 1'b1;
         cur_bank_in   = split ? bank_inc[CACHE_W-1:0] : bank_ext[CACHE_W-1:0];
      end
   end

endmodule

`default_nettype wire

// File: design/bwbs_queue.sv
`default_nettype none

module bwbs_queue #(
   parameter int QUEUE_DEPTH = bwbs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire bwbs_pkg::row_cmd_type push_data,
   output logic                       full,
   input  wire logic                  pop,
   output bwbs_pkg::row_cmd_type      head,
   output logic                       head_valid
);
   import bwbs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   row_cmd_type         mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      // pointers wrap at the last entry, so depths other than powers of two also work
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: design/bwbs_back.sv
`default_nettype none

module bwbs_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bwbs_pkg::row_cmd_type            head,
   input  wire logic                             head_valid,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_command_kind,
   output logic                                  rsp_window_select,
   output logic [bwbs_pkg::POS_W-1:0]            rsp_bank_position,
   output logic [bwbs_pkg::OFFS_W-1:0]           rsp_window_offset,
   output logic [bwbs_pkg::ADDR_SRC_W-1:0]       rsp_copy_source,
   output logic [bwbs_pkg::LEN_W-1:0]            rsp_copy_length,
   output logic                                  rsp_row_done,
   output logic                                  rsp_blit_done
);
   import bwbs_pkg::*;

   // slots of a row's run, some skipped
   localparam logic [1:0] STEP_SEL0  = 2'd0;
   localparam logic [1:0] STEP_COPY0 = 2'd1;
   localparam logic [1:0] STEP_SEL1  = 2'd2;
   localparam logic [1:0] STEP_COPY1 = 2'd3;

   logic [1:0]              count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    kind_ff, wsel_ff, row_done_ff, blit_done_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [OFFS_W-1:0]       offs_ff;
   logic [ADDR_SRC_W-1:0]   src_ff;
   logic [LEN_W-1:0]        len_ff;

   logic                    out_load, emit, last;
   logic [1:0]              slot;
   logic                    kind_c, wsel_c;
   logic [POS_W-1:0]        pos_c;
   logic [OFFS_W-1:0]       offs_c;
   logic [ADDR_SRC_W-1:0]   src_c;
   logic [LEN_W-1:0]        len_c;

   assign out_load = !rsp_valid_ff || rsp_ready;
   assign emit     = head_valid && out_load;
   assign slot     = count_ff + (head.sel_first ? 2'd0 : 2'd1);
   assign last     = (slot == (head.split ? STEP_COPY1 : STEP_COPY0));
   assign pop      = emit && last;

   assign rsp_valid_in = out_load ? head_valid : rsp_valid_ff;
   assign count_in     = emit ? (last ? 2'd0 : count_ff + 2'd1) : count_ff;

   always_comb begin
      kind_c = CMD_COPY;
      wsel_c = 1'b0;
      pos_c  = '0;
      offs_c = '0;
      src_c  = '0;
      len_c  = '0;
      unique case (slot)
         STEP_SEL0: begin
            kind_c = CMD_SELECT;
            wsel_c = head.window_sel;
            pos_c  = head.bank_pos0;
         end
         STEP_COPY0: begin
            offs_c = head.offset;
            src_c  = head.src0;
            len_c  = head.len0;
         end
         STEP_SEL1: begin
            kind_c = CMD_SELECT;
            wsel_c = head.window_sel;
            pos_c  = head.bank_pos1;
         end
         STEP_COPY1: begin
            src_c = head.src1;
            len_c = head.len1;
         end
         default: begin
            kind_c = CMD_COPY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff      <= kind_c;
         wsel_ff      <= wsel_c;
         pos_ff       <= pos_c;
         offs_ff      <= offs_c;
         src_ff       <= src_c;
         len_ff       <= len_c;
         row_done_ff  <= last;
         blit_done_ff <= last && head.final_row;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command_kind  = kind_ff;
   assign rsp_window_select = wsel_ff;
   assign rsp_bank_position = pos_ff;
   assign rsp_window_offset = offs_ff;
   assign rsp_copy_source   = src_ff;
   assign rsp_copy_length   = len_ff;
   assign rsp_row_done      = row_done_ff;
   assign rsp_blit_done     = blit_done_ff;

endmodule

`default_nettype wire

// File: design/banked_window_blit_splitter.sv
// channel   direction  handshake          payload
// req_      in         req_valid/ready    row_y, row_x, width_pixels, source_address, final_row
// rsp_      out        rsp_valid/ready    one command per item, up to four per row
// csr_      in         csr_valid/ready    csr_index, csr_data
//
// rows are accepted one per cycle while req_ready is high, into two multiply/add stages and a
// QUEUE_DEPTH-row queue (four rows by default); the back end sends one command per cycle while
// rsp_ready is high, from the queue head through an output register, so a row gives 1 to 4
// commands on rsp_, set by its bank select and cut
// reset is synchronous and clears the bank cache, queue and registers to defaults
// a stalled rsp_ holds the output register, then fills the queue, then drops req_ready
// WINDOW_BYTES must be a power of two; the block itself does not enforce it
`default_nettype none

module banked_window_blit_splitter #(
   parameter int WINDOW_BYTES = bwbs_pkg::WINDOW_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH  = bwbs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bwbs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bwbs_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [bwbs_pkg::ROW_Y_W-1:0]     req_row_y,
   input  wire logic [bwbs_pkg::ROW_X_W-1:0]     req_row_x,
   input  wire logic [bwbs_pkg::WIDTH_W-1:0]     req_width_pixels,
   input  wire logic [bwbs_pkg::ADDR_SRC_W-1:0]  req_source_address,
   input  wire logic                             req_final_row,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_command_kind,
   output logic                                  rsp_window_select,
   output logic [bwbs_pkg::POS_W-1:0]            rsp_bank_position,
   output logic [bwbs_pkg::OFFS_W-1:0]           rsp_window_offset,
   output logic [bwbs_pkg::ADDR_SRC_W-1:0]       rsp_copy_source,
   output logic [bwbs_pkg::LEN_W-1:0]            rsp_copy_length,
   output logic                                  rsp_row_done,
   output logic                                  rsp_blit_done
);
   import bwbs_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   row_cmd_type   q_data, q_head;
   logic          q_push, q_full, q_pop, q_head_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_PITCH:     cfg_in.frame_pitch       = csr_data[PITCH_W-1:0];
            CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel   = csr_data[BPP_W-1:0];
            CSR_GRANULES:        cfg_in.granules_per_bank = csr_data[GRAN_W-1:0];
            CSR_USE_WINDOW_A:    cfg_in.use_window_a      = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_pitch       <= PITCH_W'(640);
         cfg_ff.bytes_per_pixel   <= BPP_W'(1);
         cfg_ff.granules_per_bank <= GRAN_W'(1);
         cfg_ff.use_window_a      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bwbs_front #(
      .WINDOW_BYTES(WINDOW_BYTES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_row_y          (req_row_y),
      .req_row_x          (req_row_x),
      .req_width_pixels   (req_width_pixels),
      .req_source_address (req_source_address),
      .req_final_row      (req_final_row),
      .q_push             (q_push),
      .q_data             (q_data),
      .q_full             (q_full)
   );

   bwbs_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_head_valid)
   );

   bwbs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (q_head),
      .head_valid        (q_head_valid),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_command_kind  (rsp_command_kind),
      .rsp_window_select (rsp_window_select),
      .rsp_bank_position (rsp_bank_position),
      .rsp_window_offset (rsp_window_offset),
      .rsp_copy_source   (rsp_copy_source),
      .rsp_copy_length   (rsp_copy_length),
      .rsp_row_done      (rsp_row_done),
      .rsp_blit_done     (rsp_blit_done)
   );

   a_reset_clears_out: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_blit_implies_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_blit_done) |-> rsp_row_done)
      else $error("blit done without row done");

   a_select_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command_kind == CMD_SELECT) |->
         (rsp_copy_length == '0 && rsp_window_offset == '0 && !rsp_row_done))
      else $error("select command carries copy fields or ends a row");

   a_copy_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command_kind == CMD_COPY) |->
         (rsp_bank_position == '0 && !rsp_window_select))
      else $error("copy command carries select fields");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import bwbs_pkg::*;

   localparam logic [63:0] WINDOW = WINDOW_BYTES_DEFAULT;
   localparam int STALL_LIMIT = 3000;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int PHASES = 12;
   localparam int ROWS_PER_PHASE = 32;

   typedef struct packed {
      logic              kind;
      logic              wsel;
      logic [POS_W-1:0]  bank_pos;
      logic [OFFS_W-1:0] offset;
      logic [31:0]       src;
      logic [LEN_W-1:0]  len;
      logic              row_done;
      logic              blit_done;
   } blit_cmd_type;

   typedef struct packed {
      logic [ROW_Y_W-1:0] y;
      logic [ROW_X_W-1:0] x;
      logic [WIDTH_W-1:0] w;
      logic [31:0]        src;
      logic               fin;
   } blit_row_type;

   typedef struct packed {
      logic                   is_csr;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      blit_row_type           row;
      logic [2:0]             n_typed;
   } script_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ROW_Y_W-1:0] req_row_y = '0;
   logic [ROW_X_W-1:0] req_row_x = '0;
   logic [WIDTH_W-1:0] req_width_pixels = '0;
   logic [31:0] req_source_address = '0;
   logic req_final_row = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_command_kind;
   logic rsp_window_select;
   logic [POS_W-1:0] rsp_bank_position;
   logic [OFFS_W-1:0] rsp_window_offset;
   logic [31:0] rsp_copy_source;
   logic [LEN_W-1:0] rsp_copy_length;
   logic rsp_row_done;
   logic rsp_blit_done;

   // predictor copy of registers and bank cache
   logic [PITCH_W-1:0] cfg_pitch = 15'd640;
   logic [BPP_W-1:0] cfg_bpp = 3'd1;
   logic [GRAN_W-1:0] cfg_gran = 7'd1;
   logic cfg_window_a = 1'b1;
   logic [CACHE_W-1:0] cached_bank = '0;
   logic bank_valid = 1'b0;

   blit_cmd_type row_cmds [4];
   int row_cmd_cnt;
   blit_cmd_type expected_cmds[$];
   blit_cmd_type typed_cmds[$];
   script_step_type script[$];

   blit_cmd_type seen_cmd, want_cmd;
   int fail_count = 0;
   int stall_cycles = 0;
   int send_idle_pct = 33;
   int recv_idle_pct = 88;
   bit squeeze_pending = 1'b0;

   banked_window_blit_splitter u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_row_y          (req_row_y),
      .req_row_x          (req_row_x),
      .req_width_pixels   (req_width_pixels),
      .req_source_address (req_source_address),
      .req_final_row      (req_final_row),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command_kind   (rsp_command_kind),
      .rsp_window_select  (rsp_window_select),
      .rsp_bank_position  (rsp_bank_position),
      .rsp_window_offset  (rsp_window_offset),
      .rsp_copy_source    (rsp_copy_source),
      .rsp_copy_length    (rsp_copy_length),
      .rsp_row_done       (rsp_row_done),
      .rsp_blit_done      (rsp_blit_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic blit_cmd_type select_cmd(input logic wsel, input logic [POS_W-1:0] pos);
      blit_cmd_type c;
      c = '0;
      c.kind = CMD_SELECT;
      c.wsel = wsel;
      c.bank_pos = pos;
      return c;
   endfunction

   function automatic blit_cmd_type copy_cmd(input logic [OFFS_W-1:0] offs,
                                             input logic [31:0] src,
                                             input logic [LEN_W-1:0] len);
      blit_cmd_type c;
      c = '0;
      c.kind = CMD_COPY;
      c.offset = offs;
      c.src = src;
      c.len = len;
      return c;
   endfunction

   function automatic blit_cmd_type last_cmd(input blit_cmd_type c, input logic fin);
      blit_cmd_type d;
      d = c;
      d.row_done = 1'b1;
      d.blit_done = fin;
      return d;
   endfunction

   function automatic string show_cmd(input blit_cmd_type c);
      return $sformatf("kind=%0d win=%0d pos=%0d offs=%0d src=%h len=%0d rd=%0d bd=%0d",
                       c.kind, c.wsel, c.bank_pos, c.offset, c.src, c.len,
                       c.row_done, c.blit_done);
   endfunction

   function automatic void emit(input blit_cmd_type c);
      row_cmds[row_cmd_cnt] = c;
      row_cmd_cnt = row_cmd_cnt + 1;
   endfunction

   function automatic void select_bank(input logic [63:0] bank);
      logic [63:0] pos;
      pos = bank * cfg_gran;
      emit(select_cmd(!cfg_window_a, pos[POS_W-1:0]));
      cached_bank = bank[CACHE_W-1:0];
      bank_valid = 1'b1;
   endfunction

   // commands for one row, updates the bank cache
   function automatic void predict_row(input blit_row_type r);
      logic [63:0] addr, bank, offs, len, first, rest, src1;
      addr = cfg_pitch * r.y + r.x * cfg_bpp;
      bank = addr / WINDOW;
      offs = addr % WINDOW;
      len = r.w * cfg_bpp;
      if (len > MAX_COPY) len = MAX_COPY;
      row_cmd_cnt = 0;
      if (len == 0) begin
         emit(copy_cmd(offs[OFFS_W-1:0], r.src, '0));
      end else begin
         if (!bank_valid || bank[CACHE_W-1:0] != cached_bank) select_bank(bank);
         if (offs + len <= WINDOW) begin
            emit(copy_cmd(offs[OFFS_W-1:0], r.src, len[LEN_W-1:0]));
         end else begin
            // row crosses the window end: cut it and move to the next bank
            first = WINDOW - offs;
            rest = len - first;
            if (rest > WINDOW) rest = WINDOW;
            src1 = r.src + first;
            emit(copy_cmd(offs[OFFS_W-1:0], r.src, first[LEN_W-1:0]));
            select_bank(bank + 1);
            emit(copy_cmd('0, src1[31:0], rest[LEN_W-1:0]));
         end
      end
      row_cmds[row_cmd_cnt-1] = last_cmd(row_cmds[row_cmd_cnt-1], r.fin);
   endfunction

   function automatic void plan_row(input logic [ROW_Y_W-1:0] y, input logic [ROW_X_W-1:0] x,
                                    input logic [WIDTH_W-1:0] w, input logic [31:0] src,
                                    input logic fin, input int n_typed);
      script_step_type s;
      s = '0;
      s.row.y = y;
      s.row.x = x;
      s.row.w = w;
      s.row.src = src;
      s.row.fin = fin;
      s.n_typed = 3'(n_typed);
      script.push_back(s);
   endfunction

   function automatic void plan_csr(input logic [CSR_INDEX_W-1:0] idx,
                                    input logic [CSR_DATA_W-1:0] val);
      script_step_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.csr_idx = idx;
      s.csr_val = val;
      script.push_back(s);
   endfunction

   // all driving tasks start and end at a falling edge
   task automatic send_row(input blit_row_type r, input int n_typed);
      int k;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_row_y <= r.y;
      req_row_x <= r.x;
      req_width_pixels <= r.w;
      req_source_address <= r.src;
      req_final_row <= r.fin;
      do @(posedge clock); while (!req_ready);
      predict_row(r);
      if (n_typed == 0) begin
         for (k = 0; k < row_cmd_cnt; k++) expected_cmds.push_back(row_cmds[k]);
      end else begin
         for (k = 0; k < n_typed; k++) expected_cmds.push_back(typed_cmds.pop_front());
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FRAME_PITCH: cfg_pitch = val[PITCH_W-1:0];
         CSR_BYTES_PER_PIXEL: cfg_bpp = val[BPP_W-1:0];
         CSR_GRANULES: cfg_gran = val[GRAN_W-1:0];
         CSR_USE_WINDOW_A: cfg_window_a = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_setup();
      logic [CSR_DATA_W-1:0] pitch;
      case ($urandom_range(0, 7))
         0: pitch = 15'd0;
         1: pitch = 15'd1;
         2: pitch = 15'd16384;
         3: pitch = 15'h7FFF;
         default: pitch = CSR_DATA_W'($urandom_range(1, 16384));
      endcase
      write_csr(CSR_FRAME_PITCH, pitch);
      write_csr(CSR_BYTES_PER_PIXEL,
                CSR_DATA_W'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                       : $urandom_range(0, 7)));
      write_csr(CSR_GRANULES,
                CSR_DATA_W'(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(0, 127)));
      write_csr(CSR_USE_WINDOW_A, CSR_DATA_W'($urandom_range(0, 1)));
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (squeeze_pending) begin
            // long hold-off so the row queue fills and req_ready drops
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(negedge clock);
            squeeze_pending = 1'b0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         seen_cmd.kind = rsp_command_kind;
         seen_cmd.wsel = rsp_window_select;
         seen_cmd.bank_pos = rsp_bank_position;
         seen_cmd.offset = rsp_window_offset;
         seen_cmd.src = rsp_copy_source;
         seen_cmd.len = rsp_copy_length;
         seen_cmd.row_done = rsp_row_done;
         seen_cmd.blit_done = rsp_blit_done;
         if (expected_cmds.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected command: %s", show_cmd(seen_cmd));
         end else begin
            want_cmd = expected_cmds.pop_front();
            if (seen_cmd !== want_cmd) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("command mismatch at %0t", $realtime);
                  $display("  expected %s", show_cmd(want_cmd));
                  $display("  actual   %s", show_cmd(seen_cmd));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int phase, sent, h, i;
      blit_row_type r;
      logic [31:0] stride;

      // registers at reset: pitch 640, 1 byte per pixel, 1 granule, window a
      plan_row(3, 7, 0, 32'h1234_5678, 1'b0, 1);
      typed_cmds.push_back(last_cmd(copy_cmd(16'd1927, 32'h1234_5678, 15'd0), 1'b0));
      plan_row(0, 0, 1, 32'h0, 1'b0, 2);
      typed_cmds.push_back(select_cmd(1'b0, 16'd0));
      typed_cmds.push_back(last_cmd(copy_cmd(16'd0, 32'h0, 15'd1), 1'b0));
      plan_row(2047, 4095, 4096, 32'hFFFF_FFFF, 1'b1, 2);
      typed_cmds.push_back(select_cmd(1'b0, 16'd20));
      typed_cmds.push_back(last_cmd(copy_cmd(16'd3455, 32'hFFFF_FFFF, 15'd4096), 1'b1));
      plan_row(2047, 0, 1, 32'h0, 1'b0, 0);
      plan_row(102, 200, 100, 32'h0000_1000, 1'b1, 0);
      plan_row(102, 300, 5, 32'h0000_2000, 1'b0, 0);
      plan_row(0, 0, 8191, 32'h5555_AAAA, 1'b0, 0);
      // largest registers: top bank straddles into bank 1024, cached as bank 0
      plan_csr(CSR_FRAME_PITCH, 15'h7FFF);
      plan_csr(CSR_BYTES_PER_PIXEL, 15'd7);
      plan_csr(CSR_GRANULES, 15'd127);
      plan_csr(CSR_USE_WINDOW_A, 15'd0);
      plan_row(2047, 4095, 8191, 32'hFFFF_FFF0, 1'b1, 4);
      typed_cmds.push_back(select_cmd(1'b1, 16'd64385));
      typed_cmds.push_back(copy_cmd(16'd59386, 32'hFFFF_FFF0, 15'd6150));
      typed_cmds.push_back(select_cmd(1'b1, 16'd64512));
      typed_cmds.push_back(last_cmd(copy_cmd(16'd0, 32'h0000_17F6, 15'd10234), 1'b1));
      plan_row(0, 1, 1, 32'hA5A5_5A5A, 1'b0, 1);
      typed_cmds.push_back(last_cmd(copy_cmd(16'd7, 32'hA5A5_5A5A, 15'd7), 1'b0));
      plan_csr(CSR_BYTES_PER_PIXEL, 15'd0);
      plan_row(5, 4095, 4096, 32'h0F0F_0F0F, 1'b1, 0);
      plan_csr(CSR_FRAME_PITCH, 15'd0);
      plan_csr(CSR_BYTES_PER_PIXEL, 15'd4);
      plan_csr(CSR_GRANULES, 15'd0);
      plan_row(2047, 4095, 4095, 32'h8000_0000, 1'b0, 0);
      plan_row(9, 0, 4096, 32'h7FFF_FFFF, 1'b0, 0);
      plan_row(9, 0, 4097, 32'h0, 1'b1, 0);
      plan_csr(CSR_FRAME_PITCH, 15'd16384);
      plan_csr(CSR_BYTES_PER_PIXEL, 15'd3);
      plan_csr(CSR_GRANULES, 15'd64);
      plan_csr(CSR_USE_WINDOW_A, 15'd1);
      plan_row(4, 0, 10, 32'h0001_0000, 1'b0, 0);
      plan_row(3, 4095, 2000, 32'hDEAD_0000, 1'b1, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].is_csr) begin
            drain();
            write_csr(script[k].csr_idx, script[k].csr_val);
         end else begin
            send_row(script[k].row, script[k].n_typed);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         send_idle_pct = (phase < 4) ? 33 : (phase < 8) ? 88 : 0;
         recv_idle_pct = (phase < 4) ? 88 : (phase < 8) ? 33 : 0;
         drain();
         random_setup();
         if (phase == 8) squeeze_pending = 1'b1;
         sent = 0;
         while (sent < ROWS_PER_PHASE) begin
            if ($urandom_range(0, 4) != 0) begin
               // a rectangle: consecutive rows, same column and width
               h = $urandom_range(1, 8);
               r.y = ROW_Y_W'($urandom_range(0, 2048 - h));
               r.x = ROW_X_W'($urandom);
               case ($urandom_range(0, 3))
                  0: r.w = WIDTH_W'($urandom_range(1, 16));
                  1: r.w = WIDTH_W'($urandom_range(1, 512));
                  2: r.w = WIDTH_W'($urandom_range(1, 4096));
                  default: r.w = WIDTH_W'($urandom_range(0, 8191));
               endcase
               r.src = $urandom;
               stride = $urandom_range(1, 65536);
               for (i = 0; i < h; i++) begin
                  r.fin = (i == h - 1);
                  send_row(r, 0);
                  r.y = ROW_Y_W'(r.y + 1);
                  r.src = r.src + stride;
               end
               sent += h;
            end else begin
               r.y = ROW_Y_W'($urandom);
               r.x = ROW_X_W'($urandom);
               r.w = WIDTH_W'($urandom_range(0, 8191));
               r.src = $urandom;
               r.fin = 1'($urandom_range(0, 1));
               send_row(r, 0);
               sent++;
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
